FILE: rtl/sliding_window_rate_limiter_macros.svh
// assertion macros shared by the rate limiter modules
`ifndef SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

// same-cycle implication, checked on the rising clock edge
`define SWRL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swrl check failed");

// next-cycle implication, checked on the rising clock edge
`define SWRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swrl check failed");

`endif

FILE: rtl/swrl_pkg.sv
// package: widths, reset values, register indexes and control types of the rate limiter
package swrl_pkg;

   localparam int RING_DEPTH_DEFAULT = 16;

   localparam int STAMP_W      = 32;
   localparam int TOTAL_W      = 32;
   localparam int MAX_ADMITS_W = 5;
   localparam int WINDOW_W     = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 72;

   localparam logic [MAX_ADMITS_W-1:0] MAX_ADMITS_RESET = 5'd16;
   localparam logic [WINDOW_W-1:0]     WINDOW_RESET     = 16'd1000;
   localparam logic [TOTAL_W-1:0]      TOTAL_MAX        = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ADMITS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW     = 1'b1;

   // sequencer to ring: one stamp removed from the oldest end, one appended
   typedef struct packed {
      logic pop;
      logic push;
   } ring_ctrl_type;

endpackage

FILE: rtl/swrl_age_cmp.sv
// shared age compare unit: modular age of a stamp against the window length
module swrl_age_cmp
   import swrl_pkg::*;
(
   input  logic [STAMP_W-1:0]  now_time,
   input  logic [STAMP_W-1:0]  stamp,
   input  logic [WINDOW_W-1:0] window_length,
   output logic                expired
);

   logic [STAMP_W-1:0] age;

   // age wraps modulo 2^32
   assign age     = now_time - stamp;
   assign expired = (age >= STAMP_W'(window_length));

endmodule

FILE: rtl/swrl_ring.sv
// stamp ring: memory of admitted stamps with head pointer and fill count
`include "sliding_window_rate_limiter_macros.svh"

module swrl_ring
   import swrl_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT,
   parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  ring_ctrl_type      ctrl,
   input  logic [STAMP_W-1:0] push_stamp,
   output logic [STAMP_W-1:0] head_stamp,
   output logic [CNT_W-1:0]   count
);

   localparam int SUM_W = CNT_W + 1;

   logic [STAMP_W-1:0] mem [RING_DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_idx;

   // tail = (head + count) mod depth, one compare and subtract
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(RING_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(RING_DEPTH);
      end
      tail_idx = tail_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.pop) begin
         head_in  = (head_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // registered read of the oldest entry, write at the tail
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[head_ff];
      if (ctrl.push) begin
         mem[tail_idx] <= push_stamp;
      end
   end

   assign head_stamp = rd_data_ff;
   assign count      = count_ff;

   `SWRL_ASSERT_NOW(a_pop_nonempty, clock, reset, ctrl.pop, count_ff != '0)
   `SWRL_ASSERT_NOW(a_push_room, clock, reset, ctrl.push, count_ff < CNT_W'(RING_DEPTH))
   `SWRL_ASSERT_NEXT(a_pop_count, clock, reset, ctrl.pop,
                     count_ff == CNT_W'($past(count_ff) - 1'b1))

endmodule

FILE: rtl/sliding_window_rate_limiter.sv
// top level: sliding window rate limiter with a stamp ring and one age comparator
//
//   channel   direction  handshake              payload
//   req       in         req_tvalid/req_tready  tdata: now_time
//   rsp       out        rsp_tvalid/rsp_tready  tdata: admitted, admitted_total, dropped_total
//   csr       in         csr_we                 csr_index, csr_wdata
//
// a request ends in ST_CHECK; each expired stamp adds a pop, then an ST_SETTLE step:
// the single age comparator checks one ring entry per pass and the ring read is registered
// synchronous active-high reset; no clearing pass, ring entries are only read once written
// a result waits in the output register; the next request is taken meanwhile and
// stalls in its decide step until the output register frees up
`include "sliding_window_rate_limiter_macros.svh"

module sliding_window_rate_limiter
   import swrl_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request transaction
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [31:0] now_time
   // response transaction
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [0] admitted, [32:1] admitted_total,
                                               // [64:33] dropped_total, [71:65] zero
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int LIM_W = (CNT_W > MAX_ADMITS_W) ? CNT_W : MAX_ADMITS_W;

   // one-hot sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,  // ready for a request
      ST_SETTLE = 3'b010,  // ring read of the new head in flight
      ST_CHECK  = 3'b100   // compare the head stamp, pop or decide
   } state_type;

   state_type              state_ff, state_in;
   logic [STAMP_W-1:0]     now_ff, now_in;
   logic [MAX_ADMITS_W-1:0] max_admits_ff, max_admits_in;
   logic [WINDOW_W-1:0]    window_ff, window_in;
   logic [TOTAL_W-1:0]     admit_ff, admit_in;
   logic [TOTAL_W-1:0]     drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   admitted_ff, admitted_in;

   ring_ctrl_type          ring_ctrl;
   logic [STAMP_W-1:0]     head_stamp;
   logic [CNT_W-1:0]       ring_count;
   logic                   expired;
   logic                   ring_full;
   logic                   out_free;
   logic                   req_take;

   swrl_ring #(
      .RING_DEPTH (RING_DEPTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ring_ctrl),
      .push_stamp (now_ff),
      .head_stamp (head_stamp),
      .count      (ring_count)
   );

   swrl_age_cmp u_age_cmp (
      .now_time      (now_ff),
      .stamp         (head_stamp),
      .window_length (window_ff),
      .expired       (expired)
   );

   // limit is the smaller of the register and the ring depth
   assign ring_full = (LIM_W'(ring_count) >= LIM_W'(max_admits_ff))
                   || (ring_count == CNT_W'(RING_DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_take  = req_tvalid && req_tready;

   // register writes
   always_comb begin
      max_admits_in = max_admits_ff;
      window_in     = window_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_ADMITS: begin
               max_admits_in = csr_wdata[MAX_ADMITS_W-1:0];
            end
            CSR_WINDOW: begin
               window_in = csr_wdata[WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: expire from the oldest end, then admit or refuse
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      admit_in     = admit_ff;
      drop_in      = drop_ff;
      admitted_in  = admitted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ring_ctrl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in   = req_tdata[STAMP_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_SETTLE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((ring_count != '0) && expired) begin
               ring_ctrl.pop = 1'b1;
               state_in      = ST_SETTLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (ring_full) begin
                  admitted_in = 1'b0;
                  drop_in     = (drop_ff == TOTAL_MAX) ? drop_ff : drop_ff + 1'b1;
               end else begin
                  ring_ctrl.push = 1'b1;
                  admitted_in    = 1'b1;
                  admit_in       = (admit_ff == TOTAL_MAX) ? admit_ff : admit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         admit_ff      <= '0;
         drop_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         max_admits_ff <= MAX_ADMITS_RESET;
         window_ff     <= WINDOW_RESET;
      end else begin
         state_ff      <= state_in;
         admit_ff      <= admit_in;
         drop_ff       <= drop_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_admits_ff <= max_admits_in;
         window_ff     <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      admitted_ff <= admitted_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   // counters only move when a new result is loaded, so they stand in for the totals
   assign rsp_tdata  = {(RSP_DATA_W - 1 - 2 * TOTAL_W)'(0), drop_ff, admit_ff, admitted_ff};

   `SWRL_ASSERT_NEXT(a_take_to_check, clock, reset, req_take, state_ff == ST_CHECK)
   `SWRL_ASSERT_NEXT(a_stall_holds_totals, clock, reset, rsp_tvalid && !rsp_tready,
                     $stable(admit_ff) && $stable(drop_ff))
   `SWRL_ASSERT_NOW(a_push_not_full, clock, reset, ring_ctrl.push, !ring_full)

endmodule
